>>> rtl/core/htok_pkg.sv
// Shared types, byte codes and method text for the HTTP request head tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package htok_pkg;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [2:0] METHOD_LEN_MAX = 3'd7;

   localparam logic [1:0] METHOD_UNSUPPORTED = 2'd0;
   localparam logic [1:0] METHOD_GET         = 2'd1;
   localparam logic [1:0] METHOD_POST        = 2'd2;

   localparam logic [1:0] BLANK_NONE     = 2'd0;
   localparam logic [1:0] BLANK_CR       = 2'd1;
   localparam logic [1:0] BLANK_CRLF     = 2'd2;
   localparam logic [1:0] BLANK_CRLFCR   = 2'd3;

   typedef enum logic [3:0] {
      PH_METHOD    = 4'd0,
      PH_URL_START = 4'd1,
      PH_URL       = 4'd2,
      PH_VER_START = 4'd3,
      PH_VER       = 4'd4,
      PH_VER_LF    = 4'd5,
      PH_LINE      = 4'd6,
      PH_NAME      = 4'd7,
      PH_VAL_START = 4'd8,
      PH_VAL       = 4'd9,
      PH_VAL_LF    = 4'd10,
      PH_BLANK_LF  = 4'd11,
      PH_DISCARD   = 4'd12
   } phase_type;

   typedef enum logic [2:0] {
      KIND_METHOD = 3'd0,
      KIND_URL    = 3'd1,
      KIND_VER    = 3'd2,
      KIND_NAME   = 3'd3,
      KIND_VALUE  = 3'd4,
      KIND_DELIM  = 3'd5,
      KIND_END    = 3'd6
   } kind_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] method_length;
      logic       get_match;
      logic       post_match;
      logic [1:0] method_class;
      logic [1:0] blank_progress;
   } state_type;

   typedef struct packed {
      kind_type   byte_kind;
      logic       field_start;
      logic [1:0] method_code;
      logic       method_done;
      logic       parse_error;
   } result_type;

   localparam state_type STATE_REARM = '{
      phase:          PH_METHOD,
      method_length:  3'd0,
      get_match:      1'b1,
      post_match:     1'b1,
      method_class:   METHOD_UNSUPPORTED,
      blank_progress: BLANK_NONE
   };

   // "GET", indexed by position
   function automatic logic [7:0] get_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h47;
         2'd1:    c = 8'h45;
         default: c = 8'h54;
      endcase
      return c;
   endfunction

   // "POST", indexed by position
   function automatic logic [7:0] post_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h50;
         2'd1:    c = 8'h4F;
         2'd2:    c = 8'h53;
         default: c = 8'h54;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/htok_step.sv
// Per-byte tokenizer step: next parser state and tags for one request byte.
`timescale 1ns / 1ps
`default_nettype none

module htok_step
   import htok_pkg::*;
(
   input  state_type  cur_state,
   input  logic [7:0] data_byte,
   output state_type  nxt_state,
   output result_type result
);

   always_comb begin
      state_type  nxt;
      kind_type   kind;
      logic       start;
      logic       done;
      logic       err;
      logic       discard;

      nxt     = cur_state;
      kind    = KIND_DELIM;
      start   = 1'b0;
      done    = 1'b0;
      err     = 1'b0;
      discard = 1'b0;

      case (cur_state.phase)
         PH_METHOD: begin
            if (data_byte == CH_SP) begin
               if (cur_state.method_length inside {3'd3, 3'd4}) begin
                  if (cur_state.get_match) begin
                     nxt.method_class = METHOD_GET;
                  end else if (cur_state.post_match && cur_state.method_length == 3'd4) begin
                     nxt.method_class = METHOD_POST;
                  end else begin
                     nxt.method_class = METHOD_UNSUPPORTED;
                  end
                  done      = 1'b1;
                  nxt.phase = PH_URL_START;
               end else begin
                  discard = 1'b1;
               end
            end else if (data_byte == CH_CR) begin
               discard = 1'b1;
            end else begin
               kind  = KIND_METHOD;
               start = (cur_state.method_length == 3'd0);
               if (cur_state.method_length < 3'd3 &&
                   data_byte != get_char(cur_state.method_length[1:0])) begin
                  nxt.get_match = 1'b0;
               end
               if (cur_state.method_length < 3'd4 &&
                   data_byte != post_char(cur_state.method_length[1:0])) begin
                  nxt.post_match = 1'b0;
               end
               if (cur_state.method_length != METHOD_LEN_MAX) begin
                  nxt.method_length = cur_state.method_length + 3'd1;
               end
            end
         end
         PH_URL_START, PH_URL: begin
            if (data_byte == CH_SP) begin
               nxt.phase = PH_VER_START;
            end else if (data_byte == CH_CR) begin
               discard = 1'b1;
            end else begin
               kind      = KIND_URL;
               start     = (cur_state.phase == PH_URL_START);
               nxt.phase = PH_URL;
            end
         end
         PH_VER_START, PH_VER: begin
            if (data_byte == CH_CR) begin
               nxt.phase = PH_VER_LF;
            end else begin
               kind      = KIND_VER;
               start     = (cur_state.phase == PH_VER_START);
               nxt.phase = PH_VER;
            end
         end
         PH_VER_LF, PH_VAL_LF: begin
            if (data_byte == CH_LF) begin
               nxt.phase = PH_LINE;
            end else begin
               discard = 1'b1;
            end
         end
         PH_LINE: begin
            if (data_byte == CH_CR) begin
               nxt.phase = PH_BLANK_LF;
            end else if (data_byte == CH_COLON) begin
               nxt.phase = PH_VAL_START;
            end else begin
               kind      = KIND_NAME;
               start     = 1'b1;
               nxt.phase = PH_NAME;
            end
         end
         PH_NAME: begin
            if (data_byte == CH_COLON) begin
               nxt.phase = PH_VAL_START;
            end else if (data_byte == CH_CR) begin
               discard = 1'b1;
            end else begin
               kind = KIND_NAME;
            end
         end
         PH_VAL_START, PH_VAL: begin
            if (data_byte == CH_CR) begin
               nxt.phase = PH_VAL_LF;
            end else if (data_byte == CH_SP && cur_state.phase == PH_VAL_START) begin
               kind = KIND_DELIM;
            end else begin
               kind      = KIND_VALUE;
               start     = (cur_state.phase == PH_VAL_START);
               nxt.phase = PH_VAL;
            end
         end
         PH_BLANK_LF: begin
            if (data_byte == CH_LF) begin
               // keep the class for the end-of-head report
               kind             = KIND_END;
               nxt              = STATE_REARM;
               nxt.method_class = cur_state.method_class;
            end else begin
               discard = 1'b1;
            end
         end
         default: begin
            // discard until CR LF CR LF
            if (data_byte == CH_CR) begin
               nxt.blank_progress = (cur_state.blank_progress == BLANK_CRLF) ?
                                    BLANK_CRLFCR : BLANK_CR;
            end else if (data_byte == CH_LF) begin
               if (cur_state.blank_progress == BLANK_CRLFCR) begin
                  kind = KIND_END;
                  nxt  = STATE_REARM;
               end else begin
                  nxt.blank_progress = (cur_state.blank_progress == BLANK_CR) ?
                                       BLANK_CRLF : BLANK_NONE;
               end
            end else begin
               nxt.blank_progress = BLANK_NONE;
            end
         end
      endcase

      if (discard) begin
         err                = 1'b1;
         nxt.phase          = PH_DISCARD;
         nxt.method_class   = METHOD_UNSUPPORTED;
         nxt.blank_progress = (data_byte == CH_CR) ? BLANK_CR : BLANK_NONE;
      end

      result.byte_kind   = kind;
      result.field_start = start;
      result.method_code = nxt.method_class;
      result.method_done = done;
      result.parse_error = err;

      // report the class once at end of head, then clear it
      if (kind == KIND_END) begin
         nxt.method_class = METHOD_UNSUPPORTED;
      end

      nxt_state = nxt;
   end

endmodule

`default_nettype wire

>>> rtl/core/http_request_head_tokenizer.sv
// Top level of the HTTP request head tokenizer: request/result registers and parser state.
//
// Usage:
//   Feed the raw bytes of HTTP request heads on the req_ channel, one byte per
//   request. Each request yields exactly one result on the rsp_ channel: the
//   byte echoed back with its tag (method, URL, version, header name, header
//   value, delimiter, end of head), a field-start flag, the method class, a
//   method-closed flag and a format-error flag.
//   Both channels use valid/stall; a transfer takes place on a rising edge
//   with valid high and stall low.
//   A request passes two register stages, the input register and then the
//   result register, before its result shows on rsp_.
//   Throughput: one request per clock, sustained while the receiver does not
//   stall; the state update is a single short step between the two registers.
//   Reset (synchronous, active high) empties both stages and re-arms the
//   parser to await a method.
//   When the receiver stalls, the result register holds; the input register
//   still fills, and req_stall rises only once both stages are occupied.
`timescale 1ns / 1ps
`default_nettype none

module http_request_head_tokenizer
   import htok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_byte,
   output logic [2:0] rsp_byte_kind,
   output logic       rsp_field_start,
   output logic [1:0] rsp_method_code,
   output logic       rsp_method_done,
   output logic       rsp_parse_error
);

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // parser state
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;

   // result stage
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   result_type rsp_result_ff;

   logic       out_ready;

   // result register can take a new entry when empty or being drained
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   // hold the input only while both stages are full and the output is blocked
   assign req_stall = in_valid_ff && !out_ready;

   htok_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .nxt_state (state_in),
      .result    (result_in)
   );

   // control: valids and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_REARM;
      end else begin
         if (out_ready) begin
            rsp_valid_ff <= in_valid_ff;
            // advance the parser only when a byte moves into the result stage
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
      if (out_ready && in_valid_ff) begin
         rsp_byte_ff   <= in_byte_ff;
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_echo_byte   = rsp_byte_ff;
   assign rsp_byte_kind   = rsp_result_ff.byte_kind;
   assign rsp_field_start = rsp_result_ff.field_start;
   assign rsp_method_code = rsp_result_ff.method_code;
   assign rsp_method_done = rsp_result_ff.method_done;
   assign rsp_parse_error = rsp_result_ff.parse_error;

`ifndef ASSERT_OFF
   // a method can only be closed by a space
   a_done_on_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_method_done |-> rsp_echo_byte == CH_SP)
      else $error("method_done on a byte other than space");

   // an error byte is always tagged delimiter and never opens a field
   a_error_is_delim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_error |-> rsp_byte_kind == KIND_DELIM && !rsp_field_start)
      else $error("error byte tagged as field content");

   // end of head only on the LF of a blank line
   a_end_on_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_kind == KIND_END |-> rsp_echo_byte == CH_LF)
      else $error("end of head on a byte other than LF");

   // back-pressure only with a byte held in the input stage
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free stage");

   // after the parser returns from end of head, it awaits a new method
   a_rearm_after_end: assert property (@(posedge clock) disable iff (reset)
      out_ready && in_valid_ff && result_in.byte_kind == KIND_END
      |=> state_ff.phase == PH_METHOD && state_ff.method_class == METHOD_UNSUPPORTED)
      else $error("parser not re-armed after end of head");
`endif

endmodule

`default_nettype wire
